@@ sv/shlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlt_pkg: shared types and constants for the shell line tokenizer
// Request structs, lexer modes, token kinds and position limits.
// ----------------------------------------------------------------------------
package shlt_pkg;

  localparam int MAX_LINE = 4096;
  localparam int POS_W    = 13;
  localparam int MAX_RES  = 3;     // results one byte can cause
  localparam int QDEPTH   = 8;     // result queue entries
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [7:0] CH_PIPE = 8'h7C;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;

  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_PIPE    = 3'd1;
  localparam logic [2:0] KIND_IN      = 3'd2;
  localparam logic [2:0] KIND_HEREDOC = 3'd3;
  localparam logic [2:0] KIND_OUT     = 3'd4;
  localparam logic [2:0] KIND_APPEND  = 3'd5;
  localparam logic [2:0] KIND_WORD    = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_DQ,
    MODE_SQ,
    MODE_LT,
    MODE_GT
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       line_end;
  } shlt_in_t;

  typedef struct packed {
    logic [2:0]       token_kind;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic             last_of_run;
  } shlt_out_t;

  // outcome of a byte seen between tokens
  typedef struct packed {
    logic  pipe;    // emit a one-byte pipe token
    logic  open;    // a token opens here
    mode_t mode;
  } idle_t;

endpackage

@@ sv/shell_line_tokenizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_line_tokenizer_top: streaming command-line tokenizer
// Takes one byte per request and queues tokens with their byte positions.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel  (byte_valid / byte_stall / byte_req): one character per
//     request, line_end marks the last byte of a command line.
//   token channel (token_valid / token_stall / token_req): one token per
//     request; last_of_run flags the final token caused by a given byte.
// Each accepted byte is lexed in the cycle it is accepted: the mode, token
// start and byte position registers update at that edge and zero to three
// tokens are written into an 8-entry result queue. The first token is
// visible on token_req in the next cycle if the queue was empty.
// Throughput: one byte per cycle as long as the queue holds five or fewer
// tokens; byte_stall rises when a worst-case byte (three tokens) might not
// fit. Tokens leave at one per cycle while token_stall is low, so the token
// port sets the rate for token-dense text.
// A stalled token request holds its payload. Synchronous reset empties the
// queue and returns the lexer to idle at position zero; the end token of
// each line does the same to the lexer state.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_top import shlt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  shlt_in_t  byte_req,
  output logic      token_valid,
  input  logic      token_stall,
  output shlt_out_t token_req
);

  // lexer state
  mode_t            mode, mode_next;
  logic [POS_W-1:0] start, start_next;
  logic [POS_W-1:0] pos, pos_next;

  // result queue
  shlt_out_t        queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  logic             accept, pop;
  shlt_out_t        res [MAX_RES];
  logic [1:0]       n_res;

  // per-byte decode
  logic [7:0]       c;
  logic             is_sp, is_lt, is_gt, is_pipe, is_dq, is_sq;
  logic [POS_W-1:0] p, nx;
  idle_t            idl;

  function automatic shlt_out_t mk(input logic [2:0] kind,
                                   input logic [POS_W-1:0] s,
                                   input logic [POS_W-1:0] e);
    shlt_out_t r;
    r.token_kind  = kind;
    r.start_pos   = s;
    r.end_pos     = e;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign c       = byte_req.byte_value;
  assign is_sp   = (c >= CH_TAB && c <= CH_CR) || c == CH_SP;
  assign is_lt   = c == CH_LT;
  assign is_gt   = c == CH_GT;
  assign is_pipe = c == CH_PIPE;
  assign is_dq   = c == CH_DQ;
  assign is_sq   = c == CH_SQ;

  // saturating position of this byte and the one after it
  assign p  = (pos > POS_W'(MAX_LINE)) ? POS_W'(MAX_LINE) : pos;
  assign nx = (p < POS_W'(MAX_LINE)) ? p + POS_W'(1) : POS_W'(MAX_LINE);

  // what a byte does when no token is open
  always_comb begin
    idl.pipe = 1'b0;
    idl.open = 1'b0;
    idl.mode = MODE_IDLE;
    if (is_sp) begin
      idl.mode = MODE_IDLE;
    end else if (is_pipe) begin
      idl.pipe = 1'b1;
    end else begin
      idl.open = 1'b1;
      if (is_lt)      idl.mode = MODE_LT;
      else if (is_gt) idl.mode = MODE_GT;
      else if (is_dq) idl.mode = MODE_DQ;
      else if (is_sq) idl.mode = MODE_SQ;
      else            idl.mode = MODE_WORD;
    end
  end

  // lexer step
  always_comb begin
    logic run_idle;
    logic [2:0] close_kind;
    mode_next  = mode;
    start_next = start;
    pos_next   = nx;
    run_idle   = 1'b0;
    close_kind = KIND_WORD;
    n_res      = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = mk(KIND_END, '0, '0);
    end

    case (mode)
      MODE_LT, MODE_GT: begin
        mode_next = MODE_IDLE;
        if ((mode == MODE_LT && is_lt) || (mode == MODE_GT && is_gt)) begin
          res[n_res] = mk((mode == MODE_LT) ? KIND_HEREDOC : KIND_APPEND, start, nx);
          n_res      = n_res + 2'd1;
        end else begin
          res[n_res] = mk((mode == MODE_LT) ? KIND_IN : KIND_OUT, start, p);
          n_res      = n_res + 2'd1;
          run_idle   = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_sp || is_lt || is_gt || is_pipe) begin
          res[n_res] = mk(KIND_WORD, start, p);
          n_res      = n_res + 2'd1;
          mode_next  = MODE_IDLE;
          run_idle   = !is_sp;
        end else if (is_dq) begin
          mode_next = MODE_DQ;
        end else if (is_sq) begin
          mode_next = MODE_SQ;
        end
      end
      MODE_DQ: begin
        if (is_dq) mode_next = MODE_WORD;
      end
      MODE_SQ: begin
        if (is_sq) mode_next = MODE_WORD;
      end
      default: begin
        mode_next = MODE_IDLE;
        run_idle  = 1'b1;
      end
    endcase

    if (run_idle) begin
      mode_next = idl.mode;
      if (idl.open) start_next = p;
      if (idl.pipe) begin
        res[n_res] = mk(KIND_PIPE, p, nx);
        n_res      = n_res + 2'd1;
      end
    end

    // last byte: close the open token, then the end token
    if (byte_req.line_end) begin
      if (mode_next != MODE_IDLE) begin
        case (mode_next)
          MODE_LT: close_kind = KIND_IN;
          MODE_GT: close_kind = KIND_OUT;
          default: close_kind = KIND_WORD;
        endcase
        res[n_res] = mk(close_kind, start_next, nx);
        n_res      = n_res + 2'd1;
      end
      res[n_res] = mk(KIND_END, nx, nx);
      n_res      = n_res + 2'd1;
      mode_next  = MODE_IDLE;
      start_next = '0;
      pos_next   = '0;
    end

    if (n_res != 2'd0) begin
      res[n_res - 2'd1].last_of_run = 1'b1;
    end
  end

  // room for a worst-case byte
  assign byte_stall  = count > (QPTR_W+1)'(QDEPTH - MAX_RES);
  assign accept      = byte_valid && !byte_stall;
  assign token_valid = count != '0;
  assign pop         = token_valid && !token_stall;
  assign token_req   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      start  <= '0;
      pos    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        mode   <= mode_next;
        start  <= start_next;
        pos    <= pos_next;
        wr_ptr <= wr_ptr + QPTR_W'(n_res);
      end
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + ((accept) ? (QPTR_W+1)'(n_res) : '0) - (QPTR_W+1)'(pop);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < n_res) queue[wr_ptr + QPTR_W'(i)] <= res[i];
      end
    end
  end

endmodule

@@ verif/shell_line_tokenizer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_line_tokenizer_top_tb: self-checking bench for the line tokenizer
// Streams command lines one byte per request and predicts every token,
// including operators, quoting, raw bytes and the end token.
// Each token leaving the block is checked field by field against that
// prediction, in order. Bytes come with random gaps; tokens stall at random.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_top_tb import shlt_pkg::*; ();

  localparam int WATCHDOG  = 5000;  // cycles with no handshake at all
  localparam int TAIL_WAIT = 20;    // settle time once every token is in
  localparam int HOLD_LEN  = 200;   // long receiver hold-off
  localparam int RAND_CHARS = 300;

  // one pending byte request; drain makes the sender wait for all tokens first
  typedef struct {
    shlt_in_t req;
    bit       drain;
  } char_feed_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  shlt_in_t  byte_req = '0;
  logic      token_valid;
  logic      token_stall = 1'b0;
  shlt_out_t token_req;

  shell_line_tokenizer_top uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_req  (token_req)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_feed_t  char_q[$];    // bytes still to be offered
  shlt_out_t   token_q[$];   // tokens predicted, oldest first
  logic [7:0]  line_buf[$];  // line under construction

  int mismatches = 0;
  int byte_cnt   = 0;
  int token_cnt  = 0;
  int line_cnt   = 0;

  // --------------------------------------------------------------------------
  // Token predictor: a private copy of the lexer state
  // --------------------------------------------------------------------------
  mode_t       lx_mode  = MODE_IDLE;
  int unsigned lx_start = 0;
  int unsigned lx_pos   = 0;

  function automatic logic is_blank(logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SP;
  endfunction

  task automatic emit_token(logic [2:0] kind, int unsigned s, int unsigned e);
    shlt_out_t t;
    t.token_kind  = kind;
    t.start_pos   = POS_W'(s);
    t.end_pos     = POS_W'(e);
    t.last_of_run = 1'b0;
    token_q.push_back(t);
  endtask

  // byte seen between tokens: a pipe is complete at once, anything else
  // that is not blank opens a token
  task automatic open_token(logic [7:0] c, int unsigned p, int unsigned nx);
    if (!is_blank(c)) begin
      if (c == CH_PIPE) begin
        emit_token(KIND_PIPE, p, nx);
      end else begin
        lx_start = p;
        case (c)
          CH_LT:   lx_mode = MODE_LT;
          CH_GT:   lx_mode = MODE_GT;
          CH_DQ:   lx_mode = MODE_DQ;
          CH_SQ:   lx_mode = MODE_SQ;
          default: lx_mode = MODE_WORD;
        endcase
      end
    end
  endtask

  task automatic lex_char(logic [7:0] c, logic last);
    int unsigned p, nx, n0;
    logic [7:0]  dbl;
    logic [2:0]  one_kind, two_kind;
    n0 = token_q.size();
    p  = (lx_pos > MAX_LINE) ? MAX_LINE : lx_pos;
    nx = (p < MAX_LINE) ? p + 1 : MAX_LINE;
    case (lx_mode)
      MODE_LT, MODE_GT: begin
        dbl      = (lx_mode == MODE_LT) ? CH_LT : CH_GT;
        one_kind = (lx_mode == MODE_LT) ? KIND_IN : KIND_OUT;
        two_kind = (lx_mode == MODE_LT) ? KIND_HEREDOC : KIND_APPEND;
        lx_mode  = MODE_IDLE;
        if (c == dbl) begin
          emit_token(two_kind, lx_start, nx);
        end else begin
          // single redirect, then the byte starts over from idle
          emit_token(one_kind, lx_start, p);
          open_token(c, p, nx);
        end
      end
      MODE_WORD: begin
        if (is_blank(c)) begin
          emit_token(KIND_WORD, lx_start, p);
          lx_mode = MODE_IDLE;
        end else if (c == CH_LT || c == CH_GT || c == CH_PIPE) begin
          emit_token(KIND_WORD, lx_start, p);
          lx_mode = MODE_IDLE;
          open_token(c, p, nx);
        end else if (c == CH_DQ) begin
          lx_mode = MODE_DQ;
        end else if (c == CH_SQ) begin
          lx_mode = MODE_SQ;
        end
      end
      MODE_DQ: if (c == CH_DQ) lx_mode = MODE_WORD;
      MODE_SQ: if (c == CH_SQ) lx_mode = MODE_WORD;
      default: begin
        lx_mode = MODE_IDLE;
        open_token(c, p, nx);
      end
    endcase
    lx_pos = nx;
    if (last) begin
      // close whatever is open, then the end token; lexer back to reset
      case (lx_mode)
        MODE_WORD, MODE_DQ, MODE_SQ: emit_token(KIND_WORD, lx_start, nx);
        MODE_LT:                     emit_token(KIND_IN, lx_start, nx);
        MODE_GT:                     emit_token(KIND_OUT, lx_start, nx);
        default: ;
      endcase
      emit_token(KIND_END, nx, nx);
      lx_mode  = MODE_IDLE;
      lx_start = 0;
      lx_pos   = 0;
      line_cnt++;
    end
    if (token_q.size() > n0) token_q[token_q.size() - 1].last_of_run = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Line builders
  // --------------------------------------------------------------------------
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // move line_buf into the send queue, line_end on its last byte
  task automatic commit_line(bit drain);
    char_feed_t f;
    for (int i = 0; i < line_buf.size(); i++) begin
      f.req.byte_value = line_buf[i];
      f.req.line_end   = (i == line_buf.size() - 1);
      f.drain          = drain && (i == 0);
      char_q.push_back(f);
    end
    line_buf.delete();
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_DQ || c == CH_SQ);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CH_SP;
  endfunction

  // one lexical piece: word, quoted word, operator, blanks or a raw byte
  task automatic add_fragment();
    int         pick;
    logic [7:0] q;
    pick = $urandom_range(0, 19);
    if (pick < 6) begin
      repeat ($urandom_range(1, 6)) line_buf.push_back(word_char());
    end else if (pick < 9) begin
      q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
      repeat ($urandom_range(0, 2)) line_buf.push_back(word_char());
      line_buf.push_back(q);
      // quoted body may hold blanks and operator bytes
      repeat ($urandom_range(0, 5)) line_buf.push_back(8'($urandom_range(32, 126)));
      if ($urandom_range(0, 4) != 0) line_buf.push_back(q);  // sometimes left open
      repeat ($urandom_range(0, 2)) line_buf.push_back(word_char());
    end else if (pick < 13) begin
      case ($urandom_range(0, 4))
        0:       put_text("|");
        1:       put_text("<");
        2:       put_text("<<");
        3:       put_text(">");
        default: put_text(">>");
      endcase
    end else if (pick < 17) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(blank_char());
    end else begin
      line_buf.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: offers char_q in order with random gaps
  // --------------------------------------------------------------------------
  int tx_gap  = 0;
  int tx_calm = 0;

  always @(posedge clk) begin : drive_bytes
    logic       nv;
    char_feed_t f;
    int         r;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      nv = byte_valid;
      if (byte_valid && !byte_stall) begin
        lex_char(byte_req.byte_value, byte_req.line_end);
        byte_cnt++;
        nv = 1'b0;
        // mostly back to back, sometimes a short gap, rarely a long one
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 4) tx_calm = $urandom_range(20, 60);
          if (r < 60) tx_gap = 0;
          else if (r < 95) tx_gap = $urandom_range(1, 3);
          else tx_gap = $urandom_range(10, 30);
        end
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (char_q.size() > 0) begin
          // a drain mark holds the byte back until every token is out
          if (!char_q[0].drain || token_q.size() == 0) begin
            f = char_q.pop_front();
            byte_req <= f.req;
            nv = 1'b1;
          end
        end
      end
      byte_valid <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // Token receiver: random stalls plus one long hold-off to fill the queue
  // --------------------------------------------------------------------------
  int  rx_busy   = 0;
  int  rx_calm   = 0;
  int  rx_hold   = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin : drive_stall
    logic ns;
    int   r;
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      if (!hold_done && byte_cnt >= 60) begin
        rx_hold   = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        ns = 1'b1;
      end else if (rx_busy > 0) begin
        rx_busy--;
        ns = 1'b1;
      end else if (rx_calm > 0) begin
        rx_calm--;
        ns = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) rx_calm = $urandom_range(20, 60);
        else if (r < 25) rx_busy = $urandom_range(1, 3);
        else if (r < 28) rx_busy = $urandom_range(10, 30);
        ns = 1'b0;
      end
      token_stall <= ns;
    end
  end

  // --------------------------------------------------------------------------
  // Token checker
  // --------------------------------------------------------------------------
  task automatic flag_token(string why, shlt_out_t want, shlt_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("token %0d %s: ", token_cnt, why,
               "want kind=%0d start=%0d end=%0d last=%0b, ",
               want.token_kind, want.start_pos, want.end_pos, want.last_of_run,
               "got kind=%0d start=%0d end=%0d last=%0b",
               got.token_kind, got.start_pos, got.end_pos, got.last_of_run);
  endtask

  always @(posedge clk) begin : check_tokens
    shlt_out_t want;
    if (!rst && token_valid && !token_stall) begin
      if (token_q.size() == 0) begin
        flag_token("unexpected", '0, token_req);
      end else begin
        want = token_q.pop_front();
        if (token_req.token_kind !== want.token_kind ||
            token_req.start_pos !== want.start_pos ||
            token_req.end_pos !== want.end_pos ||
            token_req.last_of_run !== want.last_of_run)
          flag_token("mismatch", want, token_req);
      end
      token_cnt++;
    end
  end

  // no handshake on either port for too long means the block is stuck
  int quiet = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (byte_valid && !byte_stall) || (token_valid && !token_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles, %0d tokens outstanding",
               WATCHDOG, token_q.size());
      $display("FAIL shell_line_tokenizer_top");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int total;
    bit drained;

    // quotes with a blank inside, append, pending < left open at line end
    put_text("a\"b c\">>f<");
    commit_line(1'b0);
    // < then >, > then pipe, heredoc, pending > at line end
    put_text("<>|<<>");
    commit_line(1'b0);
    // high and zero bytes as word text, tab and CR as blanks,
    // > ended by a blank, unclosed single quote to the end
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_TAB);
    line_buf.push_back(CH_GT);
    line_buf.push_back(CH_CR);
    put_text("'q");
    commit_line(1'b0);
    // a lone blank gives just the end token
    put_text(" ");
    commit_line(1'b0);
    // three tokens from the last byte: redirect, pipe, end
    put_text("<|");
    commit_line(1'b0);
    put_text("x'y'z>a");
    commit_line(1'b0);

    // random lines; the first one past the midpoint waits for the block to empty
    total   = 0;
    drained = 1'b0;
    while (total < RAND_CHARS) begin
      repeat ($urandom_range(1, 8)) add_fragment();
      total += line_buf.size();
      if (!drained && total > RAND_CHARS / 2) begin
        drained = 1'b1;
        commit_line(1'b1);
      end else begin
        commit_line(1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || byte_valid) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (token_q.size() != 0) begin
      mismatches += token_q.size();
      $display("%0d predicted tokens never arrived", token_q.size());
    end
    $display("covered %0d bytes over %0d lines, %0d tokens checked, %0d errors",
             byte_cnt, line_cnt, token_cnt, mismatches);
    $display("included all token kinds, open quotes, a full result queue and a drained pause");
    if (mismatches == 0)
      $display("PASS shell_line_tokenizer_top");
    else
      $display("FAIL shell_line_tokenizer_top");
    $finish;
  end

endmodule
